FILE: src/mpq_pkg.sv
// Package for the sorted minimum priority queue.
// Payload structs, operation and status codes, controller/datapath command types.
// No dependencies.
package mpq_pkg;

  // operation codes carried in the func field
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // RAM read address select
  localparam logic [1:0] RD_HEAD   = 2'd0;
  localparam logic [1:0] RD_TAILM1 = 2'd1;
  localparam logic [1:0] RD_RPM1   = 2'd2;

  typedef struct packed {
    logic               func;
    logic signed [31:0] key_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] key_out;
    logic               key_valid;
    logic               queue_empty;
    logic [1:0]         status;
  } out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       take;       // latch item, set up insertion pointers
    logic [1:0] rd_sel;     // RAM read address select
    logic       shift;      // move read entry up one place
    logic       put;        // write new key at write pointer
    logic       deq;        // take head entry as result
    logic       status_we;  // record a rejection status
    logic [1:0] status;
    logic       out_load;   // move result into output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_one;   // one entry left to compare against
    logic greater;   // entry read is greater than the new key
  } sts_t;

endpackage

FILE: src/mpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mpq_dp.sv
// Datapath of the sorted priority queue: circular key store, pointers, result regs.
// Depends on mpq_pkg and mpq_ram.
module mpq_dp #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  mpq_pkg::in_t  in_item,
  input  mpq_pkg::cmd_t cmd,
  output mpq_pkg::sts_t sts,
  output mpq_pkg::out_t out_item
);

  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;
  logic [CW-1:0]      count;
  logic [AW-1:0]      wp;
  logic [AW-1:0]      rp;
  logic [CW-1:0]      pos;
  logic signed [31:0] key;
  logic signed [31:0] res_key;
  logic               res_kv;
  logic [1:0]         res_status;

  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic [31:0]        rdata;
  logic               we;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      mpq_pkg::RD_HEAD:   raddr = head;
      mpq_pkg::RD_TAILM1: raddr = ptr_dec(tail);
      mpq_pkg::RD_RPM1:   raddr = ptr_dec(rp);
      default:            raddr = head;
    endcase
  end

  // write port: shifted entry or the new key
  assign we    = cmd.shift | cmd.put;
  assign waddr = wp;
  assign wdata = cmd.shift ? rdata : key;

  mpq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status to the controller
  assign sts.full    = (count == CW'(DEPTH));
  assign sts.empty   = (count == '0);
  assign sts.pos_one = (pos == CW'(1));
  assign sts.greater = ($signed(rdata) > key);

  // occupancy pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.put) begin
        tail  <= ptr_inc(tail);
        count <= count + 1'b1;
      end else if (cmd.deq) begin
        head  <= ptr_inc(head);
        count <= count - 1'b1;
      end
    end
  end

  // insertion pointers and item key
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key <= in_item.key_in;
      wp  <= tail;
      rp  <= ptr_dec(tail);
      pos <= count;
    end else if (cmd.shift) begin
      wp  <= rp;
      rp  <= ptr_dec(rp);
      pos <= pos - 1'b1;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_key <= '0;
      res_kv  <= 1'b0;
    end
    if (cmd.deq) begin
      res_key <= rdata;
      res_kv  <= 1'b1;
    end
    // a rejection status wins over the default taken with the item
    if (cmd.status_we) begin
      res_status <= cmd.status;
    end else if (cmd.take) begin
      res_status <= mpq_pkg::ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.key_out     <= res_key;
      out_item.key_valid   <= res_kv;
      out_item.queue_empty <= (count == '0);
      out_item.status      <= res_status;
    end
  end

endmodule

FILE: src/mpq_ctrl.sv
// Controller of the sorted priority queue: sequences insertion and removal.
// Depends on mpq_pkg.
module mpq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mpq_pkg::sts_t sts,
  output mpq_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENQ  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_DEQ  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = mpq_pkg::RD_HEAD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_func == mpq_pkg::FUNC_ENQ) begin
            if (sts.full) begin
              cmd.status_we = 1'b1;
              cmd.status    = mpq_pkg::ST_FULL;
              state_next    = S_FIN;
            end else if (sts.empty) begin
              state_next = S_PUT;
            end else begin
              cmd.rd_sel = mpq_pkg::RD_TAILM1;
              state_next = S_ENQ;
            end
          end else begin
            if (sts.empty) begin
              cmd.status_we = 1'b1;
              cmd.status    = mpq_pkg::ST_EMPTY;
              state_next    = S_FIN;
            end else begin
              state_next = S_DEQ;
            end
          end
        end
      end
      S_ENQ: begin
        if (sts.greater) begin
          cmd.shift = 1'b1;
          if (sts.pos_one) begin
            state_next = S_PUT;
          end else begin
            cmd.rd_sel = mpq_pkg::RD_RPM1;
          end
        end else begin
          cmd.put    = 1'b1;
          state_next = S_FIN;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_FIN;
      end
      S_DEQ: begin
        cmd.deq    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output valid: set on load, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: src/min_priority_queue_sorted.sv
// Top level of the sorted minimum priority queue of signed 32-bit keys.
// Depends on mpq_pkg, mpq_ctrl, mpq_dp (which uses mpq_ram).
//
//   channel | port prefix | payload          | flow control
//   --------+-------------+------------------+----------------
//   input   | in_         | mpq_pkg::in_t    | in_valid / in_stall
//   output  | out_        | mpq_pkg::out_t   | out_valid / out_stall
//
// Keys sit in a circular RAM in ascending order from the head; one RAM write a
// cycle sets the speed. An enqueue shifts each stored key greater than the new
// one up one place and then writes the new key; a dequeue takes the head key; a
// rejected operation only records its status. The result waits while the output
// register still holds an untaken result. Reset empties the queue; the RAM
// is not cleared. An item is taken in only when the previous one is finished.
module min_priority_queue_sorted #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mpq_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output mpq_pkg::out_t out_item
);

  mpq_pkg::cmd_t cmd;
  mpq_pkg::sts_t sts;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (in_item.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // a dequeued key is only ever reported with an ok status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.key_valid |-> out_item.status == mpq_pkg::ST_OK)
    else $error("key reported with a failing status");

  // a dequeue from an empty queue leaves it empty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == mpq_pkg::ST_EMPTY |-> out_item.queue_empty)
    else $error("empty dequeue reported a non-empty queue");

  // a rejected enqueue means the queue is full, hence not empty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == mpq_pkg::ST_FULL |-> !out_item.queue_empty)
    else $error("full enqueue reported an empty queue");

  // after a transfer in, the block is busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for min_priority_queue_sorted: a sorted-queue tracker predicts
// every result, and random idling and output hold-offs load both channels.
// Depends on mpq_pkg and the min_priority_queue_sorted RTL.

// Tracks the keys the queue should hold and the results still owed by the block.
class min_queue_tracker;
  int                 depth;
  logic signed [31:0] held_keys[$];
  mpq_pkg::out_t      awaited_results[$];
  int                 mismatches;
  int                 results_seen;

  function new(int depth_i);
    depth        = depth_i;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  // Work out the result of an accepted request and update the held keys
  function void note_request(mpq_pkg::in_t req);
    mpq_pkg::out_t res;
    int            pos;
    res        = '0;
    res.status = mpq_pkg::ST_OK;
    if (req.func == mpq_pkg::FUNC_ENQ) begin
      if (held_keys.size() >= depth) begin
        res.status = mpq_pkg::ST_FULL;
      end else begin
        // insert after every key not greater than the new one
        pos = held_keys.size();
        while (pos > 0 && held_keys[pos - 1] > req.key_in) pos--;
        held_keys.insert(pos, req.key_in);
      end
    end else begin
      if (held_keys.size() == 0) begin
        res.status = mpq_pkg::ST_EMPTY;
      end else begin
        res.key_out   = held_keys.pop_front();
        res.key_valid = 1'b1;
      end
    end
    res.queue_empty = (held_keys.size() == 0);
    awaited_results.push_back(res);
  endfunction

  task flag_mismatch(string msg);
    $display("MISMATCH result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Compare a result transfer with the oldest outstanding prediction
  task check_result(mpq_pkg::out_t got);
    mpq_pkg::out_t want;
    results_seen++;
    if (awaited_results.size() == 0) begin
      flag_mismatch("result arrived with no request outstanding");
      return;
    end
    want = awaited_results.pop_front();
    if (got.key_out !== want.key_out)
      flag_mismatch($sformatf("key_out %0d, expected %0d", got.key_out, want.key_out));
    if (got.key_valid !== want.key_valid)
      flag_mismatch($sformatf("key_valid %b, expected %b", got.key_valid, want.key_valid));
    if (got.queue_empty !== want.queue_empty)
      flag_mismatch($sformatf("queue_empty %b, expected %b",
                              got.queue_empty, want.queue_empty));
    if (got.status !== want.status)
      flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
  endtask
endclass

module tb_top;

  localparam int                 DEPTH       = 16;
  localparam logic signed [31:0] KEY_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] KEY_MIN     = 32'sh8000_0000;
  localparam int                 HOLD_CYCLES = 80;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  mpq_pkg::in_t  in_item;
  logic          out_valid;
  logic          out_stall;
  mpq_pkg::out_t out_item;

  min_queue_tracker tracker;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_requests      = 0;

  min_priority_queue_sorted #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic mpq_pkg::in_t make_item(logic func, logic signed [31:0] key);
    mpq_pkg::in_t item;
    item.func   = func;
    item.key_in = key;
    return item;
  endfunction

  // Random request; small keys around zero give plenty of duplicates
  function automatic mpq_pkg::in_t random_item(int enq_pct);
    logic               func;
    logic signed [31:0] key;
    func = ($urandom_range(99) < enq_pct) ? mpq_pkg::FUNC_ENQ : mpq_pkg::FUNC_DEQ;
    case ($urandom_range(9))
      0:       key = KEY_MAX;
      1:       key = KEY_MIN;
      2, 3:    key = 32'($urandom_range(8)) - 32'sd4;
      default: key = $urandom;
    endcase
    return make_item(func, key);
  endfunction

  // Offer one request, after a random idle gap, and hold it until the transfer
  task automatic offer(input mpq_pkg::in_t req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_item  <= random_item(50);
      repeat (gap) @(posedge clk);
    end
    in_item  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(req);
  endtask

  // Receiver: random stalls, plus long hold-offs on request
  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served < hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(out_item);
  end

  initial begin : stimulus
    int enq_pct;
    tracker = new(DEPTH);
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dequeue, key extremes with duplicates, drain, empty again
    offer(make_item(mpq_pkg::FUNC_DEQ, KEY_MAX));
    offer(make_item(mpq_pkg::FUNC_ENQ, KEY_MAX));
    offer(make_item(mpq_pkg::FUNC_ENQ, KEY_MIN));
    offer(make_item(mpq_pkg::FUNC_ENQ, 32'sd0));
    offer(make_item(mpq_pkg::FUNC_ENQ, -32'sd1));
    offer(make_item(mpq_pkg::FUNC_ENQ, 32'sd1));
    offer(make_item(mpq_pkg::FUNC_ENQ, KEY_MAX));
    offer(make_item(mpq_pkg::FUNC_ENQ, KEY_MIN));
    offer(make_item(mpq_pkg::FUNC_ENQ, 32'sd0));
    repeat (8) offer(make_item(mpq_pkg::FUNC_DEQ, 32'sd0));
    offer(make_item(mpq_pkg::FUNC_DEQ, KEY_MIN));

    // Random: bursts biased towards filling, mixing or draining the queue
    enq_pct = 50;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
        default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
      endcase
      for (int n = 0; n < 100; n++) begin
        if (n % 20 == 0) begin
          case ($urandom_range(2))
            0:       enq_pct = 92;
            1:       enq_pct = 50;
            default: enq_pct = 10;
          endcase
        end
        // back-pressure: hold the output while the sender keeps offering
        if (phase == 0 && n == 40) hold_requests++;
        offer(random_item(enq_pct));
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for a longest enqueue before the verdict
    while (tracker.awaited_results.size() > 0) @(posedge clk);
    repeat (3 * DEPTH + 10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0) begin
      $display("min_priority_queue_sorted verification clean");
    end else begin
      $display("min_priority_queue_sorted verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("min_priority_queue_sorted verification failed");
    $finish;
  end

endmodule
